FILE: rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// types, constants and helpers for the fuzzy subsequence scorer
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int UNIT_WIDTH  = 16;
    localparam int SCORE_WIDTH = 16;
    localparam int RUN_WEIGHT  = 8;

    localparam int ADDR_WIDTH  = $clog2(PATTERN_MAX);
    localparam int COUNT_WIDTH = $clog2(PATTERN_MAX + 1);
    localparam int RUN_SHIFT   = $clog2(RUN_WEIGHT);
    localparam int GAIN_WIDTH  = COUNT_WIDTH + RUN_SHIFT + 1;
    localparam int SUM_WIDTH   = SCORE_WIDTH + 2;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TEXT   = 2'd2;

    localparam logic signed [SCORE_WIDTH-1:0] SCORE_MAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
    localparam logic signed [SCORE_WIDTH-1:0] SCORE_MIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};

    localparam logic [UNIT_WIDTH-1:0] UPPER_A    = UNIT_WIDTH'(8'h41);
    localparam logic [UNIT_WIDTH-1:0] UPPER_Z    = UNIT_WIDTH'(8'h5a);
    localparam logic [UNIT_WIDTH-1:0] CASE_DELTA = UNIT_WIDTH'(8'h20);

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] code_unit;
        logic        last_unit;
    } in_item_t;

    typedef struct packed {
        logic               matched;
        logic signed [15:0] match_score;
    } out_item_t;

    function automatic logic [UNIT_WIDTH-1:0] fold_case(input logic [UNIT_WIDTH-1:0] u);
        if (u >= UPPER_A && u <= UPPER_Z)
        begin
            return u + CASE_DELTA;
        end
        return u;
    endfunction

    function automatic logic signed [SCORE_WIDTH-1:0] saturate(
        input logic signed [SUM_WIDTH-1:0] v
    );
        if (v > SUM_WIDTH'(SCORE_MAX))
        begin
            return SCORE_MAX;
        end
        if (v < SUM_WIDTH'(SCORE_MIN))
        begin
            return SCORE_MIN;
        end
        return v[SCORE_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/fuzzy_subsequence_scorer_core.sv
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_core
// greedy fuzzy subsequence match score of a pattern against a path text
//
// usage:
//   one input channel (unit_valid, unit_stall, unit_item) carries items of
//   three kinds: clear pattern, append a pattern unit, or a text unit. text
//   units are streamed last character first; last_unit marks the final one.
//   one output channel (score_valid, score_stall, score_item) carries a
//   result for every text unit that has last_unit set: the match flag and
//   the saturated score (zero unless matched).
//   throughput is one item per cycle; the pattern unit for the next compare
//   is fetched from the pattern memory in the same cycle that the state is
//   updated, so every text unit compares against a registered read.
//   the result is registered: it is loaded into the output register at
//   the edge that accepts its last unit and can be taken at the next edge.
//   reset empties the pattern and clears the per-text state; the pattern
//   memory itself holds no reset value.
//   while a result waits under score_stall, unit_stall is raised and no item
//   is taken; otherwise an item is taken in every cycle that unit_valid is high.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               unit_valid,
    output logic               unit_stall,
    input  fss_pkg::in_item_t  unit_item,
    output logic               score_valid,
    input  logic               score_stall,
    output fss_pkg::out_item_t score_item
);
    import fss_pkg::*;

    logic [UNIT_WIDTH-1:0] pattern_mem [PATTERN_MAX];

    logic [COUNT_WIDTH-1:0]        length_reg,    length_next;
    logic [COUNT_WIDTH-1:0]        remaining_reg, remaining_next;
    logic [COUNT_WIDTH-1:0]        run_reg,       run_next;
    logic signed [SCORE_WIDTH-1:0] acc_reg,       acc_next;
    logic [UNIT_WIDTH-1:0]         cur_unit_reg;
    logic                          score_valid_reg, score_valid_next;
    out_item_t                     score_item_reg,  score_item_next;

    logic                   accept;
    logic                   out_free;
    logic                   wr_en;
    logic [ADDR_WIDTH-1:0]  wr_addr;
    logic [ADDR_WIDTH-1:0]  rd_addr;
    logic [UNIT_WIDTH-1:0]  unit;
    logic [COUNT_WIDTH-1:0] remaining_dec;
    logic [GAIN_WIDTH-1:0]  gain;
    logic                   fold_hit;
    logic                   exact_hit;
    logic                   done_ok;

    assign out_free   = !score_valid_reg || !score_stall;
    assign unit_stall = !out_free;
    assign accept     = unit_valid && out_free;
    assign unit       = unit_item.code_unit[UNIT_WIDTH-1:0];

    assign remaining_dec = remaining_reg - COUNT_WIDTH'(1);
    assign fold_hit  = fold_case(unit) == fold_case(cur_unit_reg);
    assign exact_hit = unit == cur_unit_reg;
    assign gain      = GAIN_WIDTH'({run_reg, {RUN_SHIFT{1'b0}}})
                     + GAIN_WIDTH'(1) + GAIN_WIDTH'(exact_hit);

    assign wr_addr = length_reg[ADDR_WIDTH-1:0];
    assign rd_addr = ADDR_WIDTH'(remaining_next - COUNT_WIDTH'(1));

    always_comb
    begin
        length_next      = length_reg;
        remaining_next   = remaining_reg;
        run_next         = run_reg;
        acc_next         = acc_reg;
        wr_en            = 1'b0;
        done_ok          = 1'b0;
        score_valid_next = score_valid_reg && score_stall;
        score_item_next  = score_item_reg;
        if (accept)
        begin
            unique case (unit_item.mode)
                MODE_CLEAR:
                begin
                    length_next    = '0;
                    remaining_next = '0;
                    run_next       = '0;
                    acc_next       = '0;
                end
                MODE_APPEND:
                begin
                    if (length_reg < COUNT_WIDTH'(PATTERN_MAX))
                    begin
                        wr_en       = 1'b1;
                        length_next = length_reg + COUNT_WIDTH'(1);
                    end
                    remaining_next = length_next;
                    run_next       = '0;
                    acc_next       = '0;
                end
                MODE_TEXT:
                begin
                    if (length_reg != '0)
                    begin
                        if (remaining_reg != '0 && fold_hit)
                        begin
                            acc_next = saturate(SUM_WIDTH'(acc_reg) + SUM_WIDTH'(gain));
                            run_next       = run_reg + COUNT_WIDTH'(1);
                            remaining_next = remaining_dec;
                        end
                        else
                        begin
                            acc_next = saturate(SUM_WIDTH'(acc_reg) - SUM_WIDTH'(1));
                            run_next = '0;
                        end
                    end
                    if (unit_item.last_unit)
                    begin
                        done_ok = (length_reg == '0) || (remaining_next == '0);
                        score_valid_next            = 1'b1;
                        score_item_next.matched     = done_ok;
                        score_item_next.match_score =
                            (done_ok && length_reg != '0) ? acc_next : '0;
                        remaining_next = length_reg;
                        run_next       = '0;
                        acc_next       = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pattern_mem[wr_addr] <= unit;
        end
        if (wr_en && wr_addr == rd_addr)
        begin
            cur_unit_reg <= unit;
        end
        else
        begin
            cur_unit_reg <= pattern_mem[rd_addr];
        end
        score_item_reg <= score_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg      <= '0;
            remaining_reg   <= '0;
            run_reg         <= '0;
            acc_reg         <= '0;
            score_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg      <= length_next;
            remaining_reg   <= remaining_next;
            run_reg         <= run_next;
            acc_reg         <= acc_next;
            score_valid_reg <= score_valid_next;
        end
    end

    assign score_valid = score_valid_reg;
    assign score_item  = score_item_reg;

endmodule

FILE: tb/tb_fuzzy_subsequence_scorer_core.sv
// ----------------------------------------------------------------------------
// tb_fuzzy_subsequence_scorer_core
// self-checking testbench for the fuzzy subsequence scorer
//
// loads patterns and streams path texts through the unit channel with
// random gaps, stalls the score channel at random, and checks every score
// against a behavioural scoreboard kept in step with each accepted item.
// directed tests cover empty, full and case-folded patterns, the unused
// mode and a negative score; a random phase follows.
// ----------------------------------------------------------------------------
module tb_fuzzy_subsequence_scorer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import fss_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 260;
    localparam int         FLOOR_UNITS  = 40;
    localparam int         SCORE_HI     = (1 << (SCORE_WIDTH - 1)) - 1;
    localparam int         SCORE_LO     = -(1 << (SCORE_WIDTH - 1));

    logic      clk;
    logic      rst_n       = 1'b0;
    logic      unit_valid  = 1'b0;
    logic      unit_stall;
    in_item_t  unit_item   = '0;
    logic      score_valid;
    logic      score_stall = 1'b0;
    out_item_t score_item;

    // scoreboard state
    logic [UNIT_WIDTH-1:0] pat_units [PATTERN_MAX];
    int                    pat_len   = 0;
    int                    pat_left  = 0;
    int                    run_len   = 0;
    int                    score_acc = 0;
    out_item_t             expected_scores [$];

    int error_count    = 0;
    int accepted_items = 0;
    int stall_left     = 0;
    bit calm           = 1'b0;

    fuzzy_subsequence_scorer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_valid  (unit_valid),
        .unit_stall  (unit_stall),
        .unit_item   (unit_item),
        .score_valid (score_valid),
        .score_stall (score_stall),
        .score_item  (score_item)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #40_000_000;
        $display("** fuzzy_subsequence_scorer_core: FAILED **");
        $finish;
    end

    function automatic int draw_wait();
        if (calm)
        begin
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic logic [UNIT_WIDTH-1:0] lower_ascii(input logic [UNIT_WIDTH-1:0] u);
        if (u >= 16'h41 && u <= 16'h5a)
        begin
            return u + 16'h20;
        end
        return u;
    endfunction

    function automatic int clamp_score(input int v);
        if (v > SCORE_HI)
        begin
            return SCORE_HI;
        end
        if (v < SCORE_LO)
        begin
            return SCORE_LO;
        end
        return v;
    endfunction

    function automatic logic [UNIT_WIDTH-1:0] pick_unit();
        logic [UNIT_WIDTH-1:0] edges [8];
        edges = '{16'h40, 16'h41, 16'h5a, 16'h5b, 16'h60, 16'h61, 16'h7a, 16'h7b};
        case ($urandom_range(0, 3))
            0, 1:    return UNIT_WIDTH'(($urandom_range(0, 1) ? 16'h41 : 16'h61)
                                        + $urandom_range(0, 2));
            2:       return edges[3'($urandom_range(0, 7))];
            default: return UNIT_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [UNIT_WIDTH-1:0] flip_case(input logic [UNIT_WIDTH-1:0] u);
        if (((u >= 16'h41 && u <= 16'h5a) || (u >= 16'h61 && u <= 16'h7a))
            && $urandom_range(0, 2) == 0)
        begin
            return u ^ 16'h20;
        end
        return u;
    endfunction

    task automatic restart_text();
        pat_left  = pat_len;
        run_len   = 0;
        score_acc = 0;
    endtask

    task automatic score_unit(input in_item_t it);
        logic [UNIT_WIDTH-1:0] p;
        int                    gain;
        out_item_t             res;
        case (it.mode)
            MODE_CLEAR:
            begin
                pat_len = 0;
                restart_text();
            end
            MODE_APPEND:
            begin
                if (pat_len < PATTERN_MAX)
                begin
                    pat_units[ADDR_WIDTH'(pat_len)] = it.code_unit;
                    pat_len++;
                end
                restart_text();
            end
            MODE_TEXT:
            begin
                if (pat_len != 0)
                begin
                    p = (pat_left != 0) ? pat_units[ADDR_WIDTH'(pat_left - 1)] : '0;
                    if (pat_left != 0 && lower_ascii(it.code_unit) == lower_ascii(p))
                    begin
                        gain = 1 + run_len * RUN_WEIGHT + ((it.code_unit == p) ? 1 : 0);
                        score_acc = clamp_score(score_acc + gain);
                        run_len++;
                        pat_left--;
                    end
                    else
                    begin
                        run_len   = 0;
                        score_acc = clamp_score(score_acc - 1);
                    end
                end
                if (it.last_unit)
                begin
                    res.matched     = (pat_len == 0) || (pat_left == 0);
                    res.match_score = (pat_len == 0 || !res.matched) ? '0
                                                                      : score_acc[15:0];
                    expected_scores = {expected_scores, res};
                    restart_text();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 100)
        begin
            $display("%0t ns: mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_score(input out_item_t got);
        out_item_t want;
        if (expected_scores.size() == 0)
        begin
            report_mismatch($sformatf("score with none pending (matched %0b score %0d)",
                                      got.matched, got.match_score));
            return;
        end
        want = expected_scores.pop_front();
        if (got.matched !== want.matched)
        begin
            report_mismatch($sformatf("matched %0b, wanted %0b", got.matched, want.matched));
        end
        if (got.match_score !== want.match_score)
        begin
            report_mismatch($sformatf("match_score %0d, wanted %0d",
                                      got.match_score, want.match_score));
        end
    endtask

    // score side: accept, then hold off the next result for a randomly drawn wait
    always @(posedge clk)
    begin
        if (score_valid && !score_stall)
        begin
            check_score(score_item);
            stall_left = draw_wait();
            score_stall <= (stall_left != 0);
        end
        else if (score_valid && score_stall)
        begin
            stall_left = stall_left - 1;
            if (stall_left <= 0)
            begin
                score_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [UNIT_WIDTH-1:0] unit,
                             input logic last);
        in_item_t it;
        int       gap;
        it.mode      = mode;
        it.code_unit = unit;
        it.last_unit = last;
        gap = draw_wait();
        if (gap > 0)
        begin
            unit_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        unit_valid <= 1'b1;
        unit_item  <= it;
        do
        begin
            @(posedge clk);
        end
        while (unit_stall);
        score_unit(it);
        if (mode != MODE_UNUSED)
        begin
            accepted_items++;
        end
    endtask

    task automatic wait_for_scores();
        while (expected_scores.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        // empty pattern scores zero, flag ignored outside text units
        send_item(MODE_TEXT, 16'hffff, 1'b0);
        send_item(MODE_TEXT, 16'h0000, 1'b1);
        send_item(MODE_UNUSED, 16'hffff, 1'b1);
        send_item(MODE_CLEAR, 16'hffff, 1'b1);
        send_item(MODE_APPEND, 16'h0061, 1'b1);
        send_item(MODE_APPEND, 16'h0042, 1'b0);
        send_item(MODE_APPEND, 16'h0000, 1'b0);
        send_item(MODE_APPEND, 16'hffff, 1'b1);
        // exact and folded matches, streamed last character first
        send_item(MODE_TEXT, 16'hffff, 1'b0);
        send_item(MODE_TEXT, 16'h0000, 1'b0);
        send_item(MODE_UNUSED, 16'h0000, 1'b0);
        send_item(MODE_TEXT, 16'h0062, 1'b0);
        send_item(MODE_TEXT, 16'h0041, 1'b1);
        // not matched
        send_item(MODE_TEXT, 16'h0078, 1'b1);
        // units after the pattern is used up
        send_item(MODE_TEXT, 16'hffff, 1'b0);
        send_item(MODE_TEXT, 16'h0000, 1'b0);
        send_item(MODE_TEXT, 16'h0042, 1'b0);
        send_item(MODE_TEXT, 16'h0061, 1'b0);
        send_item(MODE_TEXT, 16'h0061, 1'b1);
        // characters just outside the letters do not fold
        send_item(MODE_CLEAR, 16'h0000, 1'b0);
        send_item(MODE_APPEND, 16'h0040, 1'b0);
        send_item(MODE_APPEND, 16'h005b, 1'b0);
        send_item(MODE_TEXT, 16'h007b, 1'b0);
        send_item(MODE_TEXT, 16'h0060, 1'b1);
        send_item(MODE_TEXT, 16'h005b, 1'b0);
        send_item(MODE_TEXT, 16'h0040, 1'b1);
    endtask

    task automatic test_pattern_full();
        int k;
        send_item(MODE_CLEAR, 16'h0000, 1'b0);
        for (k = 0; k < PATTERN_MAX + 2; k++)
        begin
            send_item(MODE_APPEND, pick_unit(), k[0]);
        end
        for (k = PATTERN_MAX - 1; k >= 0; k--)
        begin
            send_item(MODE_TEXT, pat_units[ADDR_WIDTH'(k)], k == 0);
        end
        for (k = PATTERN_MAX - 1; k >= 0; k--)
        begin
            send_item(MODE_TEXT, flip_case(pat_units[ADDR_WIDTH'(k)]), k == 0);
        end
    endtask

    task automatic test_score_floor();
        calm = 1'b1;
        send_item(MODE_CLEAR, 16'h0000, 1'b0);
        send_item(MODE_APPEND, 16'h007a, 1'b0);
        repeat (FLOOR_UNITS) send_item(MODE_TEXT, 16'h0071, 1'b0);
        send_item(MODE_TEXT, 16'h005a, 1'b1);
        calm = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_item(MODE_CLEAR, 16'h0000, 1'b0);
        send_item(MODE_APPEND, 16'h0061, 1'b0);
        send_item(MODE_APPEND, 16'h0062, 1'b0);
        send_item(MODE_TEXT, 16'h0062, 1'b0);
        send_item(MODE_TEXT, 16'h0061, 1'b1);
        send_item(MODE_TEXT, 16'h0051, 1'b1);
        unit_valid <= 1'b0;
        wait_for_scores();
        send_item(MODE_TEXT, 16'h0042, 1'b0);
        send_item(MODE_TEXT, 16'h0041, 1'b1);
    endtask

    task automatic test_random();
        int                    start;
        int                    n;
        int                    k;
        int                    j;
        logic [UNIT_WIDTH-1:0] text_q [$];
        start = accepted_items;
        while (accepted_items - start < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                send_item(2'($urandom_range(0, 3)),
                          UNIT_WIDTH'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)));
            end
            else
            begin
                send_item(MODE_CLEAR, UNIT_WIDTH'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)));
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
                for (k = 0; k < n; k++)
                begin
                    send_item(MODE_APPEND, pick_unit(), 1'($urandom_range(0, 1)));
                end
                repeat ($urandom_range(1, 4))
                begin
                    text_q.delete();
                    for (k = pat_len - 1; k >= 0; k--)
                    begin
                        if ($urandom_range(0, 5) == 0)
                        begin
                            text_q = {text_q, pick_unit()};
                        end
                        if ($urandom_range(0, 9) != 0)
                        begin
                            text_q = {text_q, flip_case(pat_units[ADDR_WIDTH'(k)])};
                        end
                    end
                    repeat ($urandom_range(0, 2)) text_q = {text_q, pick_unit()};
                    if (text_q.size() == 0)
                    begin
                        text_q = {text_q, pick_unit()};
                    end
                    for (j = 0; j < text_q.size(); j++)
                    begin
                        send_item(MODE_TEXT, text_q[j], j == text_q.size() - 1);
                    end
                end
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pattern_full();
        test_score_floor();
        test_drain_pause();
        test_random();
        unit_valid <= 1'b0;
        wait_for_scores();
        repeat (4) @(posedge clk);
        if (error_count == 0 && expected_scores.size() == 0)
        begin
            $display("** fuzzy_subsequence_scorer_core: PASSED **");
        end
        else
        begin
            $display("** fuzzy_subsequence_scorer_core: FAILED **");
        end
        $finish;
    end

endmodule
